/* rtl/itrn_pkg.sv */
// Shared types, constants and token table for the integer to Roman numeral unit.
package itrn_pkg;

    // Field widths
    localparam int VALUE_W    = 12;
    localparam int SYM_W      = 7;
    localparam int TOK_IDX_W  = 4;
    localparam int NUM_TOKENS = 13;
    localparam int S_DATA_W   = 16;
    localparam int M_DATA_W   = 8;

    // Largest value that has a numeral
    localparam logic [VALUE_W-1:0] MAX_VALUE = 12'd3999;

    // ASCII codes of the numeral letters
    localparam logic [SYM_W-1:0] SYM_NONE = 7'h00;
    localparam logic [SYM_W-1:0] SYM_I    = 7'h49;
    localparam logic [SYM_W-1:0] SYM_V    = 7'h56;
    localparam logic [SYM_W-1:0] SYM_X    = 7'h58;
    localparam logic [SYM_W-1:0] SYM_L    = 7'h4C;
    localparam logic [SYM_W-1:0] SYM_C    = 7'h43;
    localparam logic [SYM_W-1:0] SYM_D    = 7'h44;
    localparam logic [SYM_W-1:0] SYM_M    = 7'h4D;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;  // capture a new item
        logic step;  // register the next letter of the run
    } itrn_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic out_free;  // output register can take a letter this cycle
        logic last_sym;  // the letter about to be registered ends the run
    } itrn_sts_t;

    // Weight of each token, largest first.
    function automatic logic [VALUE_W-1:0] token_weight(input logic [TOK_IDX_W-1:0] idx);
        logic [VALUE_W-1:0] w;
        unique case (idx)
            4'd0:    w = 12'd1000;
            4'd1:    w = 12'd900;
            4'd2:    w = 12'd500;
            4'd3:    w = 12'd400;
            4'd4:    w = 12'd100;
            4'd5:    w = 12'd90;
            4'd6:    w = 12'd50;
            4'd7:    w = 12'd40;
            4'd8:    w = 12'd10;
            4'd9:    w = 12'd9;
            4'd10:   w = 12'd5;
            4'd11:   w = 12'd4;
            default: w = 12'd1;
        endcase
        return w;
    endfunction

    // First letter of each token.
    function automatic logic [SYM_W-1:0] token_first(input logic [TOK_IDX_W-1:0] idx);
        logic [SYM_W-1:0] s;
        unique case (idx)
            4'd0:    s = SYM_M;
            4'd1:    s = SYM_C;
            4'd2:    s = SYM_D;
            4'd3:    s = SYM_C;
            4'd4:    s = SYM_C;
            4'd5:    s = SYM_X;
            4'd6:    s = SYM_L;
            4'd7:    s = SYM_X;
            4'd8:    s = SYM_X;
            4'd9:    s = SYM_I;
            4'd10:   s = SYM_V;
            4'd11:   s = SYM_I;
            default: s = SYM_I;
        endcase
        return s;
    endfunction

    // Second letter of a subtractive token, SYM_NONE for a single letter.
    function automatic logic [SYM_W-1:0] token_second(input logic [TOK_IDX_W-1:0] idx);
        logic [SYM_W-1:0] s;
        unique case (idx)
            4'd1:    s = SYM_M;
            4'd3:    s = SYM_D;
            4'd5:    s = SYM_C;
            4'd7:    s = SYM_L;
            4'd9:    s = SYM_X;
            4'd11:   s = SYM_V;
            default: s = SYM_NONE;
        endcase
        return s;
    endfunction

    // Largest token whose weight fits in the remainder (the greedy choice).
    function automatic logic [TOK_IDX_W-1:0] find_token(input logic [VALUE_W-1:0] rest);
        logic [TOK_IDX_W-1:0] idx;
        idx = TOK_IDX_W'(NUM_TOKENS - 1);
        for (int t = NUM_TOKENS - 1; t >= 0; t--) begin
            if (rest >= token_weight(TOK_IDX_W'(t))) begin
                idx = TOK_IDX_W'(t);
            end
        end
        return idx;
    endfunction

endpackage

/* rtl/itrn_ctrl.sv */
// Controller state machine: sequences item capture and letter emission.
module itrn_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  itrn_pkg::itrn_sts_t sts,
    output itrn_pkg::itrn_cmd_t cmd
);
    import itrn_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_CONV = 2'b10
    } state_t;

    state_t state_reg, state_next;

    // Next state and command decode
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CONV;
                end
            end
            ST_CONV: begin
                if (sts.out_free) begin
                    cmd.step = 1'b1;
                    if (sts.last_sym) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/itrn_dp.sv */
// Datapath: remainder, pending second letter and the registered output item.
module itrn_dp (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [itrn_pkg::VALUE_W-1:0]  value,
    input  itrn_pkg::itrn_cmd_t           cmd,
    output itrn_pkg::itrn_sts_t           sts,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [itrn_pkg::SYM_W-1:0]    symbol,
    output logic                          last,
    output logic                          error
);
    import itrn_pkg::*;

    logic [VALUE_W-1:0]   rest_reg, rest_next;
    logic                 err_reg, err_next;
    logic                 pend_reg, pend_next;
    logic [SYM_W-1:0]     pend_sym_reg, pend_sym_next;
    logic                 out_valid_reg, out_valid_next;
    logic [SYM_W-1:0]     out_sym_reg, out_sym_next;
    logic                 out_last_reg, out_last_next;
    logic                 out_err_reg, out_err_next;

    logic [TOK_IDX_W-1:0] tok;
    logic [VALUE_W-1:0]   rest_sub;
    logic [SYM_W-1:0]     tok_second;
    logic [SYM_W-1:0]     step_sym;
    logic                 step_last;

    // Greedy token choice for the current remainder
    always_comb begin
        tok        = find_token(rest_reg);
        rest_sub   = rest_reg - token_weight(tok);
        tok_second = token_second(tok);
    end

    // Letter produced by the next step
    always_comb begin
        step_sym  = token_first(tok);
        step_last = 1'b0;
        priority if (err_reg) begin
            step_sym  = SYM_NONE;
            step_last = 1'b1;
        end else if (pend_reg) begin
            step_sym  = pend_sym_reg;
            step_last = (rest_reg == '0);
        end else begin
            step_last = (tok_second == SYM_NONE) && (rest_sub == '0);
        end
    end

    assign sts.out_free = !out_valid_reg || m_tready;
    assign sts.last_sym = step_last;

    // Conversion state update
    always_comb begin
        rest_next     = rest_reg;
        err_next      = err_reg;
        pend_next     = pend_reg;
        pend_sym_next = pend_sym_reg;
        if (cmd.load) begin
            rest_next = value;
            err_next  = (value == '0) || (value > MAX_VALUE);
            pend_next = 1'b0;
        end else if (cmd.step && !err_reg) begin
            if (pend_reg) begin
                pend_next = 1'b0;
            end else begin
                rest_next     = rest_sub;
                pend_next     = (tok_second != SYM_NONE);
                pend_sym_next = tok_second;
            end
        end
    end

    // Output register update
    always_comb begin
        out_valid_next = out_valid_reg;
        out_sym_next   = out_sym_reg;
        out_last_next  = out_last_reg;
        out_err_next   = out_err_reg;
        if (cmd.step) begin
            out_valid_next = 1'b1;
            out_sym_next   = step_sym;
            out_last_next  = step_last;
            out_err_next   = err_reg;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
            err_reg       <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
            err_reg       <= err_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        rest_reg     <= rest_next;
        pend_sym_reg <= pend_sym_next;
        out_sym_reg  <= out_sym_next;
        out_last_reg <= out_last_next;
        out_err_reg  <= out_err_next;
    end

    assign m_tvalid = out_valid_reg;
    assign symbol   = out_sym_reg;
    assign last     = out_last_reg;
    assign error    = out_err_reg;

endmodule

/* rtl/integer_to_roman_numeral_unit.sv */
// Top level of the integer to Roman numeral unit.
// Converts each 12-bit input item to its Roman numeral, emitted as one ASCII
// letter per output item, most significant first, with tlast on the final
// letter. Values 1 to 3999 are converted; 0 or anything above 3999 gives one
// output item with symbol 0, tuser (error) set and tlast set. Once an item is
// accepted, the letter sequencer registers one letter per cycle while the
// output is free; a numeral has 1 to 15 letters, 15 for 3888.
// The next item is accepted as soon as the final letter has been registered,
// while that letter may still wait in the output register.
module integer_to_roman_numeral_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [itrn_pkg::S_DATA_W-1:0] s_tdata,   // [11:0] value
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [itrn_pkg::M_DATA_W-1:0] m_tdata,   // [6:0] symbol
    output logic                          m_tlast,
    output logic                          m_tuser    // [0] error
);
    import itrn_pkg::*;

    itrn_cmd_t          cmd;
    itrn_sts_t          sts;
    logic [SYM_W-1:0]   symbol;

    itrn_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    itrn_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .value    (s_tdata[VALUE_W-1:0]),
        .cmd      (cmd),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .symbol   (symbol),
        .last     (m_tlast),
        .error    (m_tuser)
    );

    assign m_tdata = {{(M_DATA_W - SYM_W){1'b0}}, symbol};

`ifndef SYNTHESIS
    // An error item is always a run of one.
    a_err_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> m_tlast)
        else $error("error item without tlast");

    // An error item carries no letter.
    a_err_no_sym: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("error item with a nonzero symbol");

    // After an item is taken, the input stays closed while it is converted.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted during a conversion");

    // A converted letter without the error flag is never zero.
    a_letter_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata[SYM_W-1:0] != SYM_NONE))
        else $error("converted letter is zero");
`endif

endmodule
